// File: design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task timer table package
// Command codes, decoded operations, table entry and result types.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SCAN    = 3'd1;
    localparam logic [2:0] CMD_CREATE  = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_SET_RUN = 3'd4;
    localparam logic [2:0] CMD_SET_PER = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SCAN    = 3'd1,
        OP_CREATE  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_SET_RUN = 3'd4,
        OP_SET_PER = 3'd5,
        OP_BAD     = 3'd7
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  key;
        logic [15:0] period;
        logic        flag;
    } t_cmd;

    typedef struct packed {
        logic        running;
        logic [15:0] counter;
        logic [15:0] period;
        logic [7:0]  key;
    } t_entry;

    typedef struct packed {
        logic       status;
        logic       due;
        logic [7:0] due_key;
        logic       last;
    } t_result;

endpackage

// File: design/ptt_ram.sv
// ----------------------------------------------------------------------------
// Periodic task timer table RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ptt_front.sv
// ----------------------------------------------------------------------------
// Periodic task timer table front end
// Accept commands, decode them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module ptt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [2:0]    i_command,
    input  logic [7:0]    i_task_key,
    input  logic [15:0]   i_period,
    input  logic          i_run_flag,
    output logic          o_cmd_valid,
    output ptt_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam logic [1:0] QFULL = 2'd2;

    ptt_pkg::t_cmd w_cmd;
    ptt_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.key    = i_task_key;
        w_cmd.period = i_period;
        w_cmd.flag   = i_run_flag;
        unique case (i_command)
            ptt_pkg::CMD_TICK:    w_cmd.op = ptt_pkg::OP_TICK;
            ptt_pkg::CMD_SCAN:    w_cmd.op = ptt_pkg::OP_SCAN;
            ptt_pkg::CMD_CREATE:  w_cmd.op = ptt_pkg::OP_CREATE;
            ptt_pkg::CMD_DELETE:  w_cmd.op = ptt_pkg::OP_DELETE;
            ptt_pkg::CMD_SET_RUN: w_cmd.op = ptt_pkg::OP_SET_RUN;
            ptt_pkg::CMD_SET_PER: w_cmd.op = ptt_pkg::OP_SET_PER;
            default:              w_cmd.op = ptt_pkg::OP_BAD;
        endcase
    end

    assign o_s_tready  = (r_fill != QFULL);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// File: design/ptt_back.sv
// ----------------------------------------------------------------------------
// Periodic task timer table back end
// Execute decoded commands over the task table, reading and then executing one entry at a time.
// ----------------------------------------------------------------------------
module ptt_back #(
    parameter int MAX_TASKS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  ptt_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    output ptt_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = $bits(ptt_pkg::t_entry);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_DEL_RD = 6'b001000,
        S_DEL_WR = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    ptt_pkg::t_cmd    r_cmd, n_cmd;
    logic             r_status, n_status;
    logic             r_pend_v, n_pend_v;
    logic [7:0]       r_pend_key, n_pend_key;
    logic [IW-1:0]    r_found, n_found;
    logic             r_ov, n_ov;
    ptt_pkg::t_result r_res, n_res;
    logic             w_load;
    logic             w_out_free;
    logic [CW-1:0]    w_last_idx;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [IW-1:0]    w_raddr;
    ptt_pkg::t_entry  w_wdata;
    ptt_pkg::t_entry  w_rd;
    logic [EW-1:0]    w_rdata;
    logic             w_hit;

    ptt_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd       = w_rdata;
    assign w_out_free = !r_ov || i_res_ready;
    assign w_last_idx = CW'(r_count - 1'b1);
    assign w_hit      = (w_rd.counter == 16'd0) && w_rd.running;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_status   = r_status;
        n_pend_v   = r_pend_v;
        n_pend_key = r_pend_key;
        n_found    = r_found;
        n_res      = r_res;
        w_load     = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_idx[IW-1:0];
        w_wdata    = w_rd;
        w_raddr    = r_idx[IW-1:0];
        o_cmd_pop  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_status  = 1'b0;
                    n_pend_v  = 1'b0;
                    n_state   = S_READ;
                    case (i_cmd.op)
                        ptt_pkg::OP_CREATE: begin
                            n_state = S_DONE;
                            if (r_count < CW'(MAX_TASKS)) begin
                                w_we            = 1'b1;
                                w_waddr         = r_count[IW-1:0];
                                w_wdata.running = 1'b1;
                                w_wdata.counter = i_cmd.period;
                                w_wdata.period  = i_cmd.period;
                                w_wdata.key     = i_cmd.key;
                                n_count         = CW'(r_count + 1'b1);
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        ptt_pkg::OP_BAD: begin
                            n_status = 1'b1;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_idx == r_count) begin
                    n_state = S_DONE;
                    if (r_cmd.op != ptt_pkg::OP_TICK && r_cmd.op != ptt_pkg::OP_SCAN) begin
                        n_status = 1'b1;
                    end
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op) inside
                    ptt_pkg::OP_TICK: begin
                        if (w_rd.counter != 16'd0) begin
                            w_we            = 1'b1;
                            w_wdata.counter = w_rd.counter - 16'd1;
                        end
                        n_idx   = CW'(r_idx + 1'b1);
                        n_state = S_READ;
                    end
                    ptt_pkg::OP_SCAN: begin
                        if (!(w_hit && w_rd.key != 8'd0 && r_pend_v && !w_out_free)) begin
                            if (w_hit) begin
                                w_we            = 1'b1;
                                w_wdata.counter = w_rd.period;
                                if (w_rd.key != 8'd0) begin
                                    if (r_pend_v) begin
                                        w_load        = 1'b1;
                                        n_res.status  = 1'b0;
                                        n_res.due     = 1'b1;
                                        n_res.due_key = r_pend_key;
                                        n_res.last    = 1'b0;
                                    end
                                    n_pend_v   = 1'b1;
                                    n_pend_key = w_rd.key;
                                end
                            end
                            n_idx   = CW'(r_idx + 1'b1);
                            n_state = S_READ;
                        end
                    end
                    ptt_pkg::OP_DELETE, ptt_pkg::OP_SET_RUN, ptt_pkg::OP_SET_PER: begin
                        if (w_rd.key == r_cmd.key) begin
                            n_state = S_DONE;
                            if (r_cmd.op == ptt_pkg::OP_SET_RUN) begin
                                w_we            = 1'b1;
                                w_wdata.running = r_cmd.flag;
                            end else if (r_cmd.op == ptt_pkg::OP_SET_PER) begin
                                w_we            = 1'b1;
                                w_wdata.counter = r_cmd.period;
                                w_wdata.period  = r_cmd.period;
                            end else begin
                                n_found = r_idx[IW-1:0];
                                n_state = S_DEL_RD;
                            end
                        end else begin
                            n_idx   = CW'(r_idx + 1'b1);
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DEL_RD: begin
                w_raddr = w_last_idx[IW-1:0];
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                w_raddr = w_last_idx[IW-1:0];
                w_we    = 1'b1;
                w_waddr = r_found;
                w_wdata = w_rd;
                n_count = w_last_idx;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load        = 1'b1;
                    n_res.status  = r_status;
                    n_res.due     = r_pend_v;
                    n_res.due_key = r_pend_v ? r_pend_key : 8'd0;
                    n_res.last    = 1'b1;
                    n_pend_v      = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (w_load) begin
            n_ov = 1'b1;
        end else if (i_res_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_status   <= n_status;
        r_pend_key <= n_pend_key;
        r_found    <= n_found;
        r_res      <= n_res;
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count above table size");

    a_exec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($past(r_state) == S_READ || $past(r_state) == S_EXEC))
        else $error("entry executed without a read");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cmd.op == ptt_pkg::OP_SCAN))
        else $error("pending due key outside a run scan");

    a_delete_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_WR) |-> (r_count != '0))
        else $error("delete move on an empty table");
`endif

endmodule

// File: design/periodic_task_timer_table_top.sv
// Create and invalid commands go from the idle state straight to the done state;
// tick, run scan and key lookups walk the table with a read state and an execute
// state per entry; delete adds a read and a write state for the move of the last entry.
// The back end takes a new command only once the one in progress has loaded its result.
// Two commands queue behind the one in progress; the result register frees the back end.
// Reset: synchronous, active low; clears the task count, queue and handshake state.
// ----------------------------------------------------------------------------
// Periodic task timer table
// Table of periodic tasks with tick, run scan, create, delete and update commands.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_top #(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // task_key[7:0], period[23:8], run_flag[24], zero
    input  logic [2:0]  i_s_tuser,  // command[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // status[0], due_key[8:1], zero
    output logic        o_m_tuser,  // due[0]
    output logic        o_m_tlast
);

    logic             w_cmd_valid;
    logic             w_cmd_pop;
    ptt_pkg::t_cmd    w_cmd;
    ptt_pkg::t_result w_res;

    ptt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_command   (i_s_tuser),
        .i_task_key  (i_s_tdata[7:0]),
        .i_period    (i_s_tdata[23:8]),
        .i_run_flag  (i_s_tdata[24]),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    ptt_back #(
        .MAX_TASKS(MAX_TASKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {7'd0, w_res.due_key, w_res.status};
    assign o_m_tuser = w_res.due;
    assign o_m_tlast = w_res.last;

endmodule
